FILE: src/differential_drive_speed_profile_unit_assert.svh
// ----------------------------------------------------------------------------
// differential_drive_speed_profile_unit_assert
// Assertion macros for the speed profile unit.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_SPEED_PROFILE_UNIT_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_SPEED_PROFILE_UNIT_ASSERT_SVH

// When the antecedent holds, the consequent must hold in the same cycle.
`define DDSP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("speed profile unit: same-cycle check failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define DDSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("speed profile unit: next-cycle check failed");

`endif

FILE: src/ddsp_pkg.sv
// ----------------------------------------------------------------------------
// ddsp_pkg
// Shared constants, register indexes and controller/datapath types.
// ----------------------------------------------------------------------------
package ddsp_pkg;

    // Default structural parameters.
    localparam int DEF_COUNTER_BITS = 16;
    localparam int DEF_DUTY_BITS    = 16;
    localparam int DEF_ERR_BITS     = 40;

    // Fixed field widths.
    localparam int CNT_W   = 16;
    localparam int GYRO_W  = 32;
    localparam int TGT_W   = 18;
    localparam int SPD_W   = 23;
    localparam int DUTY_W  = 16;
    localparam int TRAV_W  = 32;
    localparam int GAIN_W  = 12;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;

    // The gyro divider retires two quotient bits per cycle.
    localparam int DIV_CYCLES = GYRO_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_FB_MODE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_GYRO_DIV  = 3'd1;
    localparam logic [IDX_W-1:0] REG_LIN_KP    = 3'd2;
    localparam logic [IDX_W-1:0] REG_LIN_KD    = 3'd3;
    localparam logic [IDX_W-1:0] REG_ANG_KP    = 3'd4;
    localparam logic [IDX_W-1:0] REG_ANG_KD    = 3'd5;
    localparam logic [IDX_W-1:0] REG_LIN_STEP  = 3'd6;
    localparam logic [IDX_W-1:0] REG_ANG_STEP  = 3'd7;

    // Rotational feedback modes.
    localparam logic [1:0] FB_ENC_GYRO = 2'd0;
    localparam logic [1:0] FB_ENC_ONLY = 2'd1;
    localparam logic [1:0] FB_GYRO_ONLY = 2'd2;

    // Register reset values.
    localparam logic [1:0]        RST_FB_MODE  = FB_ENC_GYRO;
    localparam logic [15:0]       RST_GYRO_DIV = 16'd5700;
    localparam logic [GAIN_W-1:0] RST_LIN_KP   = 12'd32;
    localparam logic [GAIN_W-1:0] RST_LIN_KD   = 12'd64;
    localparam logic [GAIN_W-1:0] RST_ANG_KP   = 12'd16;
    localparam logic [GAIN_W-1:0] RST_ANG_KD   = 12'd192;
    localparam logic [15:0]       RST_LIN_STEP = 16'd2904;
    localparam logic [15:0]       RST_ANG_STEP = 16'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic upd;
        logic err;
        logic mul;
        logic sum;
        logic fin;
    } t_ddsp_cmd;

endpackage

FILE: src/differential_drive_speed_profile_unit.sv
// Usage: one input item per control tick. An item is taken at a clock edge where
// i_valid is high and o_stall is low; a result item leaves where o_valid is high
// and i_stall is low. Every input item yields exactly one result item.
// A tick item (command 0) runs gyro division at two quotient bits per cycle,
// then state update, error update, PD multiply, PD sum and result write, in
// that order. The block takes no new item until the result of the current one
// is written. A reset-profile item (command 1) clears the state and goes
// straight to the result write.
// The finished result sits in an output register, so the block accepts and works
// on the next item while a result waits. If the receiver still stalls when the
// following result is ready, the block holds in its last step until the slot frees.
// Configuration writes are taken on any cycle with i_cfg_we high.
// After i_rst_n the profile state is zero, the registers hold their default
// values and no result is pending.
// ----------------------------------------------------------------------------
// differential_drive_speed_profile_unit
// Speed ramp and dual PD position loop for a differential-drive robot.
// ----------------------------------------------------------------------------
module differential_drive_speed_profile_unit import ddsp_pkg::*; #(
    parameter int COUNTER_BITS = DEF_COUNTER_BITS,
    parameter int DUTY_BITS    = DEF_DUTY_BITS,
    parameter int ERR_BITS     = DEF_ERR_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_command,
    input  logic [CNT_W-1:0]         i_left_count,
    input  logic [CNT_W-1:0]         i_right_count,
    input  logic signed [GYRO_W-1:0] i_gyro_rate,
    input  logic signed [TGT_W-1:0]  i_target_lin,
    input  logic signed [TGT_W-1:0]  i_target_ang,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [DUTY_W-1:0]        o_left_duty,
    output logic                     o_left_dir,
    output logic [DUTY_W-1:0]        o_right_duty,
    output logic                     o_right_dir,
    output logic signed [TRAV_W-1:0] o_travelled
);

`include "differential_drive_speed_profile_unit_assert.svh"

    t_ddsp_cmd w_cmd;

    // Sequencer.
    ddsp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_cmd     (w_cmd)
    );

    // Arithmetic and state.
    ddsp_dpath #(
        .COUNTER_BITS (COUNTER_BITS),
        .DUTY_BITS    (DUTY_BITS),
        .ERR_BITS     (ERR_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_command     (i_command),
        .i_left_count  (i_left_count),
        .i_right_count (i_right_count),
        .i_gyro_rate   (i_gyro_rate),
        .i_target_lin  (i_target_lin),
        .i_target_ang  (i_target_ang),
        .o_left_duty   (o_left_duty),
        .o_left_dir    (o_left_dir),
        .o_right_duty  (o_right_duty),
        .o_right_dir   (o_right_dir),
        .o_travelled   (o_travelled)
    );

    // A taken item keeps the input side busy in the next cycle.
    `DDSP_ASSERT_NEXT(a_busy_after_take, i_valid && !o_stall, o_stall)
    // A result is written only into a free or departing output slot.
    `DDSP_ASSERT_SAME(a_write_free_slot, w_cmd.fin, !o_valid || !i_stall)
    // A result write always raises the output valid.
    `DDSP_ASSERT_NEXT(a_write_sets_valid, w_cmd.fin, o_valid)

endmodule

FILE: src/ddsp_ctrl.sv
// ----------------------------------------------------------------------------
// ddsp_ctrl
// Sequencer for one item: gyro division, state update, PD products, result.
// ----------------------------------------------------------------------------
module ddsp_ctrl import ddsp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic      i_command,
    output logic      o_stall,
    output logic      o_valid,
    input  logic      i_stall,
    output t_ddsp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_ERR  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

    logic [2:0]           r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic                 w_acc;
    logic                 w_write;

    // Input is taken only while idle; the result slot is written when free.
    assign w_acc   = i_valid && (r_state == S_IDLE);
    assign w_write = (r_state == S_FIN) && (!r_out_valid || !i_stall);
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    // Commands to the datapath.
    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = w_acc;
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.upd      = (r_state == S_UPD);
        o_cmd.err      = (r_state == S_ERR);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.sum      = (r_state == S_SUM);
        o_cmd.fin      = w_write;
    end

    // Next state.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = w_write || (r_out_valid && i_stall);
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_acc) begin
                    n_state = i_command ? S_FIN : S_DIV;
                end
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: n_state = S_ERR;
            S_ERR: n_state = S_MUL;
            S_MUL: n_state = S_SUM;
            S_SUM: n_state = S_FIN;
            S_FIN: begin
                if (w_write) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: src/ddsp_dpath.sv
// ----------------------------------------------------------------------------
// ddsp_dpath
// Configuration registers, profile state, gyro divider, PD arithmetic and
// the result register.
// ----------------------------------------------------------------------------
module ddsp_dpath import ddsp_pkg::*; #(
    parameter int COUNTER_BITS = DEF_COUNTER_BITS,
    parameter int DUTY_BITS    = DEF_DUTY_BITS,
    parameter int ERR_BITS     = DEF_ERR_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ddsp_cmd                i_cmd,
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_command,
    input  logic [CNT_W-1:0]         i_left_count,
    input  logic [CNT_W-1:0]         i_right_count,
    input  logic signed [GYRO_W-1:0] i_gyro_rate,
    input  logic signed [TGT_W-1:0]  i_target_lin,
    input  logic signed [TGT_W-1:0]  i_target_ang,
    output logic [DUTY_W-1:0]        o_left_duty,
    output logic                     o_left_dir,
    output logic [DUTY_W-1:0]        o_right_duty,
    output logic                     o_right_dir,
    output logic signed [TRAV_W-1:0] o_travelled
);

    localparam int CB  = COUNTER_BITS;
    localparam int ROT_W = 34;
    localparam int EXW = ((ERR_BITS > ROT_W + 4) ? ERR_BITS : ROT_W + 4) + 2;
    localparam int PPW = ERR_BITS + 13;
    localparam int PDW = ERR_BITS + 14;
    localparam int PW  = ERR_BITS + 15;
    localparam int DW  = ERR_BITS + 7;
    localparam int LW  = ERR_BITS + 8;
    localparam logic signed [EXW-1:0] EHI = EXW'({1'b0, {(ERR_BITS-1){1'b1}}});
    localparam logic signed [EXW-1:0] ELO = -EHI - EXW'(1);
    localparam logic [LW-1:0] DMAX = LW'({DUTY_BITS{1'b1}});

    // Configuration registers.
    logic [1:0]        r_fb_mode;
    logic [15:0]       r_gyro_div;
    logic [GAIN_W-1:0] r_lin_kp, r_lin_kd, r_ang_kp, r_ang_kd;
    logic [15:0]       r_lin_step, r_ang_step;

    // Captured item.
    logic                    r_cmd;
    logic [CB-1:0]           r_lc, r_rc;
    logic signed [TGT_W-1:0] r_tgt_lin, r_tgt_ang;
    logic                    r_gneg;

    // Divider.
    logic [16:0]       r_rem;
    logic [GYRO_W-1:0] r_quo;

    // Profile state.
    logic [CB-1:0]                r_prev_l, r_prev_r;
    logic [31:0]                  r_tot_l, r_tot_r;
    logic signed [SPD_W-1:0]      r_spd_lin, r_spd_ang;
    logic signed [ERR_BITS-1:0]   r_err_lin, r_err_ang, r_last_lin, r_last_ang;

    // Stage registers.
    logic signed [CB:0]      r_enc_x;
    logic signed [ROT_W-1:0] r_rot;
    logic signed [PPW-1:0]   r_pl_p, r_pa_p;
    logic signed [PDW-1:0]   r_pl_d, r_pa_d;
    logic signed [DW-1:0]    r_dx, r_dw;

    // Result register.
    logic [DUTY_W-1:0]        r_o_ld, r_o_rd;
    logic                     r_o_ldir, r_o_rdir;
    logic signed [TRAV_W-1:0] r_o_trav;

    // Combinational values.
    logic [16:0]             w_rs1, w_rs2, w_rem1, w_rem2;
    logic                    w_ge1, w_ge2;
    logic [GYRO_W-1:0]       w_quo2;
    logic signed [CB-1:0]    w_dl, w_dr;
    logic signed [CB:0]      w_enc_x, w_enc_w;
    logic signed [32:0]      w_gfb;
    logic signed [ROT_W-1:0] w_rot;
    logic signed [EXW-1:0]   w_el, w_ea;
    logic signed [PW-1:0]    w_sl, w_sa;
    logic signed [LW-1:0]    w_left, w_right;
    logic [LW-1:0]           w_lmag, w_rmag;
    logic signed [32:0]      w_tsum, w_thalf;

    // Ramp a Q4 speed toward target * 16, clamping at the target.
    function automatic logic signed [SPD_W-1:0] ramp(
        input logic signed [SPD_W-1:0] cur,
        input logic signed [TGT_W-1:0] tgt,
        input logic [15:0]             step
    );
        logic signed [24:0] c;
        logic signed [24:0] t;
        logic signed [24:0] s;
        c = 25'(cur);
        t = 25'(tgt) <<< 4;
        s = signed'({9'b0, step});
        if (c < t) begin
            c = c + s;
            if (c > t) c = t;
        end else if (c > t) begin
            c = c - s;
            if (c < t) c = t;
        end
        return c[SPD_W-1:0];
    endfunction

    // Saturate an error sum to the signed error range.
    function automatic logic signed [ERR_BITS-1:0] sat_err(input logic signed [EXW-1:0] v);
        logic signed [EXW-1:0] r;
        r = v;
        if (v > EHI) r = EHI;
        if (v < ELO) r = ELO;
        return r[ERR_BITS-1:0];
    endfunction

    // Two restoring division steps per cycle on the gyro magnitude.
    always_comb begin
        w_rs1  = {r_rem[15:0], r_quo[GYRO_W-1]};
        w_ge1  = (w_rs1 >= {1'b0, r_gyro_div});
        w_rem1 = w_ge1 ? (w_rs1 - {1'b0, r_gyro_div}) : w_rs1;
        w_rs2  = {w_rem1[15:0], r_quo[GYRO_W-2]};
        w_ge2  = (w_rs2 >= {1'b0, r_gyro_div});
        w_rem2 = w_ge2 ? (w_rs2 - {1'b0, r_gyro_div}) : w_rs2;
        w_quo2 = {r_quo[GYRO_W-3:0], w_ge1, w_ge2};
    end

    // Encoder deltas and rotational feedback.
    always_comb begin
        w_dl    = signed'(r_lc - r_prev_l);
        w_dr    = signed'(r_rc - r_prev_r);
        w_enc_x = (CB+1)'(w_dr) + (CB+1)'(w_dl);
        w_enc_w = (CB+1)'(w_dr) - (CB+1)'(w_dl);
        if (r_gyro_div == '0) begin
            w_gfb = '0;
        end else if (r_gneg) begin
            w_gfb = -signed'({1'b0, r_quo});
        end else begin
            w_gfb = signed'({1'b0, r_quo});
        end
        case (r_fb_mode)
            FB_GYRO_ONLY: w_rot = ROT_W'(w_gfb);
            FB_ENC_ONLY:  w_rot = ROT_W'(w_enc_w);
            default:      w_rot = ROT_W'(w_enc_w) + ROT_W'(w_gfb);
        endcase
    end

    // Position error sums.
    always_comb begin
        w_el = EXW'(r_err_lin) + EXW'(r_spd_lin) - (EXW'(r_enc_x) <<< 4);
        w_ea = EXW'(r_err_ang) + EXW'(r_spd_ang) - (EXW'(r_rot) <<< 4);
    end

    // PD sums, divided by 256 toward zero.
    always_comb begin
        w_sl = PW'(r_pl_p) + PW'(r_pl_d);
        w_sa = PW'(r_pa_p) + PW'(r_pa_d);
        w_sl = (w_sl + (w_sl[PW-1] ? PW'(255) : PW'(0))) >>> 8;
        w_sa = (w_sa + (w_sa[PW-1] ? PW'(255) : PW'(0))) >>> 8;
    end

    // Side drives, magnitudes and distance travelled.
    always_comb begin
        w_left  = LW'(r_dx) - LW'(r_dw);
        w_right = LW'(r_dx) + LW'(r_dw);
        w_lmag  = w_left[LW-1]  ? LW'(-w_left)  : LW'(w_left);
        w_rmag  = w_right[LW-1] ? LW'(-w_right) : LW'(w_right);
        w_tsum  = 33'(signed'(r_tot_l)) + 33'(signed'(r_tot_r));
        w_thalf = (w_tsum + (w_tsum[32] ? 33'sd1 : 33'sd0)) >>> 1;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_mode  <= RST_FB_MODE;
            r_gyro_div <= RST_GYRO_DIV;
            r_lin_kp   <= RST_LIN_KP;
            r_lin_kd   <= RST_LIN_KD;
            r_ang_kp   <= RST_ANG_KP;
            r_ang_kd   <= RST_ANG_KD;
            r_lin_step <= RST_LIN_STEP;
            r_ang_step <= RST_ANG_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FB_MODE:  r_fb_mode  <= i_cfg_data[1:0];
                REG_GYRO_DIV: r_gyro_div <= i_cfg_data;
                REG_LIN_KP:   r_lin_kp   <= i_cfg_data[GAIN_W-1:0];
                REG_LIN_KD:   r_lin_kd   <= i_cfg_data[GAIN_W-1:0];
                REG_ANG_KP:   r_ang_kp   <= i_cfg_data[GAIN_W-1:0];
                REG_ANG_KD:   r_ang_kd   <= i_cfg_data[GAIN_W-1:0];
                REG_LIN_STEP: r_lin_step <= i_cfg_data;
                REG_ANG_STEP: r_ang_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Profile state: updated by a tick, cleared by a reset command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_l   <= '0;
            r_prev_r   <= '0;
            r_tot_l    <= '0;
            r_tot_r    <= '0;
            r_spd_lin  <= '0;
            r_spd_ang  <= '0;
            r_err_lin  <= '0;
            r_err_ang  <= '0;
            r_last_lin <= '0;
            r_last_ang <= '0;
        end else if (i_cmd.fin && r_cmd) begin
            r_prev_l   <= '0;
            r_prev_r   <= '0;
            r_tot_l    <= '0;
            r_tot_r    <= '0;
            r_spd_lin  <= '0;
            r_spd_ang  <= '0;
            r_err_lin  <= '0;
            r_err_ang  <= '0;
            r_last_lin <= '0;
            r_last_ang <= '0;
        end else begin
            if (i_cmd.upd) begin
                r_prev_l  <= r_lc;
                r_prev_r  <= r_rc;
                r_tot_l   <= r_tot_l + 32'(w_dl);
                r_tot_r   <= r_tot_r + 32'(w_dr);
                r_spd_lin <= ramp(r_spd_lin, r_tgt_lin, r_lin_step);
                r_spd_ang <= ramp(r_spd_ang, r_tgt_ang, r_ang_step);
            end
            if (i_cmd.err) begin
                r_err_lin <= sat_err(w_el);
                r_err_ang <= sat_err(w_ea);
            end
            if (i_cmd.mul) begin
                r_last_lin <= r_err_lin;
                r_last_ang <= r_err_ang;
            end
        end
    end

    // Item capture, divider, and stage registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd     <= i_command;
            r_lc      <= CB'(i_left_count);
            r_rc      <= CB'(i_right_count);
            r_tgt_lin <= i_target_lin;
            r_tgt_ang <= i_target_ang;
            r_gneg    <= i_gyro_rate[GYRO_W-1];
            r_rem     <= '0;
            r_quo     <= i_gyro_rate[GYRO_W-1] ? GYRO_W'(-i_gyro_rate) : GYRO_W'(i_gyro_rate);
        end else if (i_cmd.div_step) begin
            r_rem <= w_rem2;
            r_quo <= w_quo2;
        end
        if (i_cmd.upd) begin
            r_enc_x <= w_enc_x;
            r_rot   <= w_rot;
        end
        if (i_cmd.mul) begin
            r_pl_p <= signed'({1'b0, r_lin_kp}) * r_err_lin;
            r_pa_p <= signed'({1'b0, r_ang_kp}) * r_err_ang;
            r_pl_d <= signed'({1'b0, r_lin_kd}) *
                      ((ERR_BITS+1)'(r_err_lin) - (ERR_BITS+1)'(r_last_lin));
            r_pa_d <= signed'({1'b0, r_ang_kd}) *
                      ((ERR_BITS+1)'(r_err_ang) - (ERR_BITS+1)'(r_last_ang));
        end
        if (i_cmd.sum) begin
            r_dx <= w_sl[DW-1:0];
            r_dw <= w_sa[DW-1:0];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            if (r_cmd) begin
                r_o_ld   <= '0;
                r_o_ldir <= 1'b1;
                r_o_rd   <= '0;
                r_o_rdir <= 1'b1;
                r_o_trav <= '0;
            end else begin
                r_o_ld   <= DUTY_W'((w_lmag > DMAX) ? DMAX : w_lmag);
                r_o_ldir <= !w_left[LW-1];
                r_o_rd   <= DUTY_W'((w_rmag > DMAX) ? DMAX : w_rmag);
                r_o_rdir <= w_right[LW-1] || (w_right == '0);
                r_o_trav <= w_thalf[TRAV_W-1:0];
            end
        end
    end

    assign o_left_duty  = r_o_ld;
    assign o_left_dir   = r_o_ldir;
    assign o_right_duty = r_o_rd;
    assign o_right_dir  = r_o_rdir;
    assign o_travelled  = r_o_trav;

endmodule

FILE: tb/ddsp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ddsp_checker
// Watches the configuration port and both item channels of the speed profile
// unit, predicts every result from its own copy of the state and registers,
// and compares each result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ddsp_checker import ddsp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic                     i_command,
    input  logic [CNT_W-1:0]         i_left_count,
    input  logic [CNT_W-1:0]         i_right_count,
    input  logic signed [GYRO_W-1:0] i_gyro_rate,
    input  logic signed [TGT_W-1:0]  i_target_lin,
    input  logic signed [TGT_W-1:0]  i_target_ang,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic [DUTY_W-1:0]        i_left_duty,
    input  logic                     i_left_dir,
    input  logic [DUTY_W-1:0]        i_right_duty,
    input  logic                     i_right_dir,
    input  logic signed [TRAV_W-1:0] i_travelled,
    output int                       o_errors,
    output int                       o_pending
);

    localparam longint ERR_HI = (64'sd1 <<< (DEF_ERR_BITS - 1)) - 1;
    localparam longint ERR_LO = -ERR_HI - 1;
    localparam longint DUTY_MAX = (64'sd1 <<< DEF_DUTY_BITS) - 1;

    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic              left_dir;
        logic [DUTY_W-1:0] right_duty;
        logic              right_dir;
        logic [TRAV_W-1:0] travelled;
    } t_drive_out;

    t_drive_out drive_queue[$];

    // Register copies.
    logic [1:0]        fb_mode;
    logic [15:0]       gyro_div;
    logic [GAIN_W-1:0] lin_kp, lin_kd, ang_kp, ang_kd;
    logic [15:0]       lin_step, ang_step;

    // Profile state.
    logic [CNT_W-1:0]  prev_left, prev_right;
    logic [31:0]       total_left, total_right;
    longint            speed_lin, speed_ang;
    longint            err_lin, err_ang, last_err_lin, last_err_ang;

    assign o_pending = drive_queue.size();

    function automatic longint ramp_speed(longint cur, longint target, logic [15:0] step);
        longint s;
        s = longint'({48'd0, step});
        if (cur < target) begin
            cur = cur + s;
            if (cur > target) cur = target;
        end else if (cur > target) begin
            cur = cur - s;
            if (cur < target) cur = target;
        end
        return cur;
    endfunction

    function automatic longint clamp_err(longint v);
        if (v > ERR_HI) return ERR_HI;
        if (v < ERR_LO) return ERR_LO;
        return v;
    endfunction

    function automatic longint pd_drive(longint e, longint last, logic [GAIN_W-1:0] kp,
                                        logic [GAIN_W-1:0] kd);
        longint acc;
        acc = longint'({52'd0, kp}) * e + longint'({52'd0, kd}) * (e - last);
        return acc / 256;
    endfunction

    function automatic logic [DUTY_W-1:0] duty_of(longint v);
        longint mag;
        mag = (v < 0) ? -v : v;
        return (mag > DUTY_MAX) ? DUTY_W'(DUTY_MAX) : DUTY_W'(mag);
    endfunction

    task automatic clear_profile();
        prev_left = '0;
        prev_right = '0;
        total_left = '0;
        total_right = '0;
        speed_lin = 0;
        speed_ang = 0;
        err_lin = 0;
        err_ang = 0;
        last_err_lin = 0;
        last_err_ang = 0;
    endtask

    // Work out the result of one control tick and advance the state.
    task automatic predict_tick(output t_drive_out res);
        logic [CNT_W-1:0] dl16, dr16;
        longint dl, dr, enc_x, enc_w, gyro_fb, rot, dx, dw, left, right, trav;
        dl16 = i_left_count - prev_left;
        dr16 = i_right_count - prev_right;
        dl = longint'($signed(dl16));
        dr = longint'($signed(dr16));
        prev_left = i_left_count;
        prev_right = i_right_count;
        total_left = total_left + dl[31:0];
        total_right = total_right + dr[31:0];
        speed_lin = ramp_speed(speed_lin, longint'(i_target_lin) * 16, lin_step);
        speed_ang = ramp_speed(speed_ang, longint'(i_target_ang) * 16, ang_step);
        enc_x = dr + dl;
        enc_w = dr - dl;
        gyro_fb = (gyro_div == 0) ? 0 : longint'(i_gyro_rate) / longint'({48'd0, gyro_div});
        case (fb_mode)
            FB_GYRO_ONLY: rot = gyro_fb;
            FB_ENC_ONLY:  rot = enc_w;
            default:      rot = enc_w + gyro_fb;
        endcase
        err_lin = clamp_err(err_lin + speed_lin - enc_x * 16);
        err_ang = clamp_err(err_ang + speed_ang - rot * 16);
        dx = pd_drive(err_lin, last_err_lin, lin_kp, lin_kd);
        dw = pd_drive(err_ang, last_err_ang, ang_kp, ang_kd);
        last_err_lin = err_lin;
        last_err_ang = err_ang;
        left = dx - dw;
        right = dx + dw;
        res.left_duty = duty_of(left);
        res.left_dir = (left >= 0);
        res.right_duty = duty_of(right);
        res.right_dir = (right <= 0);
        trav = (longint'($signed(total_left)) + longint'($signed(total_right))) / 2;
        res.travelled = trav[31:0];
    endtask

    always @(posedge i_clk) begin
        t_drive_out want;
        if (!i_rst_n) begin
            fb_mode = RST_FB_MODE;
            gyro_div = RST_GYRO_DIV;
            lin_kp = RST_LIN_KP;
            lin_kd = RST_LIN_KD;
            ang_kp = RST_ANG_KP;
            ang_kd = RST_ANG_KD;
            lin_step = RST_LIN_STEP;
            ang_step = RST_ANG_STEP;
            clear_profile();
            drive_queue.delete();
            o_errors = 0;
        end else begin
            // Compare a delivered result with the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                if (drive_queue.size() == 0) begin
                    $display("%0t: result item with no prediction waiting", $time);
                    o_errors++;
                end else begin
                    want = drive_queue.pop_front();
                    if (i_left_duty !== want.left_duty) begin
                        $display("%0t: left_duty expected %0d actual %0d",
                                 $time, want.left_duty, i_left_duty);
                        o_errors++;
                    end
                    if (i_left_dir !== want.left_dir) begin
                        $display("%0t: left_dir expected %0d actual %0d",
                                 $time, want.left_dir, i_left_dir);
                        o_errors++;
                    end
                    if (i_right_duty !== want.right_duty) begin
                        $display("%0t: right_duty expected %0d actual %0d",
                                 $time, want.right_duty, i_right_duty);
                        o_errors++;
                    end
                    if (i_right_dir !== want.right_dir) begin
                        $display("%0t: right_dir expected %0d actual %0d",
                                 $time, want.right_dir, i_right_dir);
                        o_errors++;
                    end
                    if (i_travelled !== want.travelled) begin
                        $display("%0t: travelled expected %0d actual %0d",
                                 $time, $signed(want.travelled), i_travelled);
                        o_errors++;
                    end
                end
            end

            // Track register writes.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FB_MODE:  fb_mode = i_cfg_data[1:0];
                    REG_GYRO_DIV: gyro_div = i_cfg_data;
                    REG_LIN_KP:   lin_kp = i_cfg_data[GAIN_W-1:0];
                    REG_LIN_KD:   lin_kd = i_cfg_data[GAIN_W-1:0];
                    REG_ANG_KP:   ang_kp = i_cfg_data[GAIN_W-1:0];
                    REG_ANG_KD:   ang_kd = i_cfg_data[GAIN_W-1:0];
                    REG_LIN_STEP: lin_step = i_cfg_data;
                    REG_ANG_STEP: ang_step = i_cfg_data;
                    default: ;
                endcase
            end

            // Predict the result of an accepted item.
            if (i_in_valid && !i_in_stall) begin
                if (i_command) begin
                    clear_profile();
                    want = '{left_duty: '0, left_dir: 1'b1, right_duty: '0,
                             right_dir: 1'b1, travelled: '0};
                end else begin
                    predict_tick(want);
                end
                drive_queue.push_back(want);
            end
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the speed profile unit with directed and random control ticks and
// profile resets under several register settings and idling patterns; the
// checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module testbench;
    import ddsp_pkg::*;

    localparam int  CYCLE_LIMIT   = 600000;
    localparam int  SETTLE_CYCLES = 40;
    localparam int  PHASE_ITEMS   = 110;
    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_RESET    = 1'b1;
    localparam logic [1:0] FB_SPARE = 2'd3;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [IDX_W-1:0]         i_cfg_index;
    logic [CFG_W-1:0]         i_cfg_data;
    logic                     i_valid;
    logic                     o_stall;
    logic                     i_command;
    logic [CNT_W-1:0]         i_left_count;
    logic [CNT_W-1:0]         i_right_count;
    logic signed [GYRO_W-1:0] i_gyro_rate;
    logic signed [TGT_W-1:0]  i_target_lin;
    logic signed [TGT_W-1:0]  i_target_ang;
    logic                     o_valid;
    logic                     i_stall;
    logic [DUTY_W-1:0]        o_left_duty;
    logic                     o_left_dir;
    logic [DUTY_W-1:0]        o_right_duty;
    logic                     o_right_dir;
    logic signed [TRAV_W-1:0] o_travelled;

    int errors;
    int pending;
    int cycles;
    int send_idle_pct;
    int recv_stall_pct;
    logic [CNT_W-1:0] left_pos;
    logic [CNT_W-1:0] right_pos;

    differential_drive_speed_profile_unit uut (.*);

    ddsp_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_command(i_command), .i_left_count(i_left_count),
        .i_right_count(i_right_count), .i_gyro_rate(i_gyro_rate),
        .i_target_lin(i_target_lin), .i_target_ang(i_target_ang),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_left_duty(o_left_duty), .i_left_dir(o_left_dir),
        .i_right_duty(o_right_duty), .i_right_dir(o_right_dir),
        .i_travelled(o_travelled),
        .o_errors(errors), .o_pending(pending)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver stalls at the rate of the current phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic cfg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every predicted result has arrived and the block is quiet.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Offer one item, idling first at the sender's rate, and hold until taken.
    task automatic send_item(logic cmd, logic [CNT_W-1:0] lc, logic [CNT_W-1:0] rc,
                             logic [GYRO_W-1:0] gyro, logic [TGT_W-1:0] tlin,
                             logic [TGT_W-1:0] tang);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_left_count <= lc;
        i_right_count <= rc;
        i_gyro_rate <= gyro;
        i_target_lin <= tlin;
        i_target_ang <= tang;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Mostly smooth wheel motion with modest targets; some items are noise.
    task automatic send_random();
        logic cmd;
        logic [GYRO_W-1:0] gyro;
        logic [TGT_W-1:0] tlin, tang;
        cmd = ($urandom_range(99) < 3) ? CMD_RESET : CMD_TICK;
        if ($urandom_range(99) < 88) begin
            left_pos = left_pos + CNT_W'($urandom_range(400)) - CNT_W'(200);
            right_pos = right_pos + CNT_W'($urandom_range(400)) - CNT_W'(200);
            gyro = GYRO_W'($urandom_range(400000)) - GYRO_W'(200000);
            tlin = TGT_W'($urandom_range(600)) - TGT_W'(300);
            tang = TGT_W'($urandom_range(200)) - TGT_W'(100);
        end else begin
            left_pos = CNT_W'($urandom);
            right_pos = CNT_W'($urandom);
            gyro = $urandom;
            tlin = TGT_W'($urandom);
            tang = TGT_W'($urandom);
        end
        if (cmd == CMD_RESET) begin
            left_pos = '0;
            right_pos = '0;
        end
        send_item(cmd, left_pos, right_pos, gyro, tlin, tang);
    endtask

    // Register settings: the extremes, then random ones.
    task automatic load_setting(int sel);
        logic [1:0] mode;
        case (sel)
            0: begin
                cfg_write(REG_FB_MODE, CFG_W'(FB_GYRO_ONLY));
                cfg_write(REG_GYRO_DIV, 16'hFFFF);
                cfg_write(REG_LIN_KP, 16'hFFFF);
                cfg_write(REG_LIN_KD, 16'hFFFF);
                cfg_write(REG_ANG_KP, 16'hFFFF);
                cfg_write(REG_ANG_KD, 16'hFFFF);
                cfg_write(REG_LIN_STEP, 16'hFFFF);
                cfg_write(REG_ANG_STEP, 16'hFFFF);
            end
            1: begin
                cfg_write(REG_FB_MODE, CFG_W'(FB_SPARE));
                cfg_write(REG_GYRO_DIV, '0);
                cfg_write(REG_LIN_KP, '0);
                cfg_write(REG_LIN_KD, '0);
                cfg_write(REG_ANG_KP, 16'd1);
                cfg_write(REG_ANG_KD, 16'd4095);
                cfg_write(REG_LIN_STEP, '0);
                cfg_write(REG_ANG_STEP, 16'd1);
            end
            2: begin
                cfg_write(REG_FB_MODE, CFG_W'(FB_ENC_ONLY));
                cfg_write(REG_GYRO_DIV, 16'd1);
                cfg_write(REG_LIN_KP, CFG_W'($urandom));
                cfg_write(REG_LIN_KD, CFG_W'($urandom));
                cfg_write(REG_ANG_KP, CFG_W'($urandom));
                cfg_write(REG_ANG_KD, CFG_W'($urandom));
                cfg_write(REG_LIN_STEP, CFG_W'($urandom_range(4000)));
                cfg_write(REG_ANG_STEP, CFG_W'($urandom_range(4000)));
            end
            default: begin
                mode = 2'($urandom);
                cfg_write(REG_FB_MODE, CFG_W'(mode));
                cfg_write(REG_GYRO_DIV, CFG_W'($urandom_range(65535, 1)));
                cfg_write(REG_LIN_KP, CFG_W'($urandom_range(300)));
                cfg_write(REG_LIN_KD, CFG_W'($urandom_range(300)));
                cfg_write(REG_ANG_KP, CFG_W'($urandom_range(300)));
                cfg_write(REG_ANG_KD, CFG_W'($urandom_range(300)));
                cfg_write(REG_LIN_STEP, CFG_W'($urandom));
                cfg_write(REG_ANG_STEP, CFG_W'($urandom_range(200)));
            end
        endcase
    endtask

    initial begin
        int n;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        left_pos = '0;
        right_pos = '0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_command <= CMD_TICK;
        i_left_count <= '0;
        i_right_count <= '0;
        i_gyro_rate <= '0;
        i_target_lin <= '0;
        i_target_ang <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items under the reset register values.
        send_item(CMD_TICK, 16'd0, 16'd0, 32'd0, 18'd0, 18'd0);
        send_item(CMD_TICK, 16'd100, 16'd120, 32'd5700, 18'd40, 18'd3);
        send_item(CMD_TICK, 16'hFFFF, 16'd1, 32'h7FFF_FFFF, 18'h1FFFF, 18'h1FFFF);
        send_item(CMD_TICK, 16'd0, 16'd0, 32'h8000_0000, 18'h20000, 18'h20000);
        send_item(CMD_TICK, 16'h7FFF, 16'h8000, 32'hFFFF_FFFF, 18'h1FFFF, 18'h20000);
        send_item(CMD_TICK, 16'hFFFF, 16'h0000, 32'd1, 18'h20000, 18'h1FFFF);
        send_item(CMD_TICK, 16'h7FFF, 16'h7FFF, 32'hAAAA_AAAA, 18'h2AAAA, 18'h15555);
        send_item(CMD_TICK, 16'h5555, 16'hAAAA, 32'h5555_5555, 18'h15555, 18'h2AAAA);
        send_item(CMD_RESET, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 18'h3FFFF, 18'h3FFFF);
        send_item(CMD_TICK, 16'd10, 16'hFFF6, 32'hFFFF_E9BC, 18'h3FFFF, 18'd1);
        for (n = 0; n < 12; n++) begin
            send_item(CMD_TICK, 16'(n * 16'h1555), 16'(16'hFFFF - n * 16'h1555),
                      32'(n * 32'h0AAA_AAAA), 18'h1FFFF, 18'h20000);
        end
        send_item(CMD_RESET, 16'd0, 16'd0, 32'd0, 18'd0, 18'd0);
        drain();

        // Random phases, each under its own registers and idling.
        for (int phase = 0; phase < 7; phase++) begin
            load_setting(phase);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 3 && n == PHASE_ITEMS / 2) begin
                    // Hold off until every result sent so far in this phase is in.
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
                send_random();
            end
            drain();
        end

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
